FILE: hdl/ubt_pkg.sv
// ----------------------------------------------------------------------------
// ubt_pkg
// Types, constants and saturating helpers shared by the Urey-Bradley kernel.
// ----------------------------------------------------------------------------
package ubt_pkg;

	localparam int SM_LAT   = 4;            // saturating multiplier latency
	localparam int SQ_BITS  = 34;           // root bits, one stage each
	localparam int SQ_LAT   = SQ_BITS;
	localparam int DIV_BITS = 80;           // quotient bits, one stage each
	localparam int DIV_LAT  = DIV_BITS + 2;

	localparam logic signed [63:0] Q_ONE      = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] Q_ONE_HALF = 64'sh0000_0001_8000_0000;
	localparam logic signed [63:0] Q_MAX      = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] Q_MIN      = 64'sh8000_0000_0000_0000;

	typedef enum logic [7:0] {
		CFG_ENERGY_UNIT     = 8'd0,
		CFG_CUBIC           = 8'd1,
		CFG_QUARTIC         = 8'd2,
		CFG_ENERGY_ENABLE   = 8'd3,
		CFG_GRADIENT_ENABLE = 8'd4,
		CFG_VIRIAL_ENABLE   = 8'd5
	} cfg_index_t;

	typedef struct packed {
		logic [15:0]        first_atom;
		logic [15:0]        second_atom;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [30:0]        ideal_distance;
		logic signed [31:0] force_constant;
	} ubt_term_t;

	typedef struct packed {
		logic [15:0]        out_first_atom;
		logic [15:0]        out_second_atom;
		logic signed [63:0] energy;
		logic signed [63:0] grad_x;
		logic signed [63:0] grad_y;
		logic signed [63:0] grad_z;
		logic signed [63:0] virial_xx;
		logic signed [63:0] virial_yx;
		logic signed [63:0] virial_zx;
		logic signed [63:0] virial_yy;
		logic signed [63:0] virial_zy;
		logic signed [63:0] virial_zz;
	} ubt_result_t;

	// signed magnitude to saturated two's complement
	function automatic logic signed [63:0] sat_sign(input logic hi_nz, input logic [63:0] lo,
			input logic neg);
		logic signed [63:0] r;
		if (hi_nz) begin
			r = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			r = lo[63] ? Q_MIN : -$signed(lo);
		end else begin
			r = lo[63] ? Q_MAX : $signed(lo);
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? Q_MIN : Q_MAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	// signed Q16.16 word widened to Q32.32
	function automatic logic signed [63:0] to_q32(input logic [31:0] v);
		return {{16{v[31]}}, v, 16'b0};
	endfunction

endpackage

FILE: hdl/urey_bradley_term_force_top.sv
// ----------------------------------------------------------------------------
// urey_bradley_term_force_top
// Urey-Bradley term kernel: distance, anharmonic energy, gradient and virial.
// ----------------------------------------------------------------------------
// the result path runs through the 34-stage square root and the 82-stage
//   divider in series with the multiply chain; throughput one item every
//   cycle, busy stays low
// the receiver cannot stall: result_valid pulses for one cycle per item
// reset (arst_n low) clears the valid chain and loads register defaults
module urey_bradley_term_force_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ubt_pkg::ubt_term_t    term,
	output logic                  result_valid,
	output ubt_pkg::ubt_result_t  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	import ubt_pkg::*;

	// stage times, counted in registers after the item is taken
	localparam int T_IN  = 1;
	localparam int T_D   = 2;
	localparam int T_R2  = 5;
	localparam int T_RAC = T_R2 + SQ_LAT;
	localparam int T_DT  = T_RAC + 1;
	localparam int T_L1  = T_DT + SM_LAT;
	localparam int T_L2  = T_L1 + SM_LAT;
	localparam int T_P   = T_L2 + 1;
	localparam int T_L3  = T_P + SM_LAT;
	localparam int T_DE  = T_L3 + DIV_LAT;
	localparam int T_G   = T_DE + SM_LAT;
	localparam int T_V   = T_G + SM_LAT;

	// delay line lengths
	localparam int N_ATOM  = T_V - T_IN;
	localparam int N_IDEAL = T_RAC - T_IN;
	localparam int N_UK    = T_L1 - (T_IN + SM_LAT);
	localparam int N_U2K   = T_DT - (T_IN + SM_LAT);
	localparam int N_RAC   = T_L3 - T_RAC;
	localparam int N_DDE   = T_DE - T_D;
	localparam int N_DG    = T_G - T_D;
	localparam int N_E     = T_V - T_L3;

	// ---------------- configuration registers ----------------
	logic [31:0] unit_q, cubic_q, quartic_q;
	logic        en_energy_q, en_grad_q, en_vir_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;    // one item per cycle, never held off

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q      <= 32'h0001_0000;
			cubic_q     <= '0;
			quartic_q   <= '0;
			en_energy_q <= 1'b1;
			en_grad_q   <= 1'b1;
			en_vir_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENERGY_UNIT:     unit_q      <= cfg_data;
				CFG_CUBIC:           cubic_q     <= cfg_data;
				CFG_QUARTIC:         quartic_q   <= cfg_data;
				CFG_ENERGY_ENABLE:   en_energy_q <= cfg_data[0];
				CFG_GRADIENT_ENABLE: en_grad_q   <= cfg_data[0];
				CFG_VIRIAL_ENABLE:   en_vir_q    <= cfg_data[0];
				default: ;           // unknown index ignored
			endcase
		end
	end

	// constants derived from the registers; the user must change them only while idle, the block does not enforce it
	logic signed [63:0] unit64, c64, q64, u2, q2, c15;
	assign unit64 = to_q32(unit_q);
	assign c64    = to_q32(cubic_q);
	assign q64    = to_q32(quartic_q);
	assign u2     = sadd(unit64, unit64);
	assign q2     = sadd(q64, q64);

	ubt_smul u_c15 (.clk(clk), .a(c64), .b(Q_ONE_HALF), .p(c15));

	// ---------------- valid chain ----------------
	logic vld_q [T_V];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T_V; i++) vld_q[i] <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < T_V; i++) vld_q[i] <= vld_q[i-1];
			result_valid <= vld_q[T_V-1];
		end
	end

	// ---------------- geometry ----------------
	ubt_term_t          in_s1;
	logic signed [63:0] k_s1;
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic [32:0]        mx_s3, my_s3, mz_s3;
	logic [65:0]        sx_s4, sy_s4, sz_s4;
	logic [67:0]        r2_s5;

	assign k_s1 = to_q32(in_s1.force_constant);

	always_ff @(posedge clk) begin
		in_s1 <= term;
		dx_s2 <= 33'(in_s1.first_x) - 33'(in_s1.second_x);
		dy_s2 <= 33'(in_s1.first_y) - 33'(in_s1.second_y);
		dz_s2 <= 33'(in_s1.first_z) - 33'(in_s1.second_z);
		mx_s3 <= dx_s2[32] ? 33'(-dx_s2) : 33'(dx_s2);
		my_s3 <= dy_s2[32] ? 33'(-dy_s2) : 33'(dy_s2);
		mz_s3 <= dz_s2[32] ? 33'(-dz_s2) : 33'(dz_s2);
		sx_s4 <= mx_s3 * mx_s3;
		sy_s4 <= my_s3 * my_s3;
		sz_s4 <= mz_s3 * mz_s3;
		r2_s5 <= 68'(sx_s4) + 68'(sy_s4) + 68'(sz_s4);
	end

	logic [33:0] rac;
	ubt_sqrt u_sqrt (.clk(clk), .r2(r2_s5), .root(rac));

	// per-item force constant products, formed early and held back
	logic signed [63:0] uk, u2k;
	ubt_smul u_uk  (.clk(clk), .a(unit64), .b(k_s1), .p(uk));
	ubt_smul u_u2k (.clk(clk), .a(u2),     .b(k_s1), .p(u2k));

	// ---------------- delay lines ----------------
	logic [31:0]        atom_dl  [N_ATOM];
	logic [30:0]        ideal_dl [N_IDEAL];
	logic signed [63:0] uk_dl    [N_UK];
	logic signed [63:0] u2k_dl   [N_U2K];
	logic [33:0]        rac_dl   [N_RAC];
	logic signed [32:0] dx_dl    [N_DG];
	logic signed [32:0] dy_dl    [N_DG];
	logic signed [32:0] dz_dl    [N_DG];
	logic signed [63:0] cdt_dl   [SM_LAT];
	logic signed [63:0] c15dt_dl [SM_LAT];
	logic signed [63:0] t1_dl    [SM_LAT+1];
	logic signed [63:0] e_dl     [N_E];
	logic signed [63:0] gx_dl    [SM_LAT];
	logic signed [63:0] gy_dl    [SM_LAT];
	logic signed [63:0] gz_dl    [SM_LAT];

	logic signed [63:0] dt_q, dt2, cdt, c15dt, t1;
	logic signed [63:0] qdt2, q2dt2, ukdt2, ukdt2_s, poly_s, poly2_s;
	logic signed [63:0] e, deddt, de, gx, gy, gz;
	logic signed [63:0] vxx, vyx, vzx, vyy, vzy, vzz;

	always_ff @(posedge clk) begin
		atom_dl[0]  <= {in_s1.first_atom, in_s1.second_atom};
		ideal_dl[0] <= in_s1.ideal_distance;
		uk_dl[0]    <= uk;
		u2k_dl[0]   <= u2k;
		rac_dl[0]   <= rac;
		dx_dl[0]    <= dx_s2;
		dy_dl[0]    <= dy_s2;
		dz_dl[0]    <= dz_s2;
		cdt_dl[0]   <= cdt;
		c15dt_dl[0] <= c15dt;
		t1_dl[0]    <= t1;
		e_dl[0]     <= e;
		gx_dl[0]    <= gx;
		gy_dl[0]    <= gy;
		gz_dl[0]    <= gz;
		for (int i = 1; i < N_ATOM; i++)   atom_dl[i]  <= atom_dl[i-1];
		for (int i = 1; i < N_IDEAL; i++)  ideal_dl[i] <= ideal_dl[i-1];
		for (int i = 1; i < N_UK; i++)     uk_dl[i]    <= uk_dl[i-1];
		for (int i = 1; i < N_U2K; i++)    u2k_dl[i]   <= u2k_dl[i-1];
		for (int i = 1; i < N_RAC; i++)    rac_dl[i]   <= rac_dl[i-1];
		for (int i = 1; i < N_DG; i++) begin
			dx_dl[i] <= dx_dl[i-1];
			dy_dl[i] <= dy_dl[i-1];
			dz_dl[i] <= dz_dl[i-1];
		end
		for (int i = 1; i < SM_LAT; i++) begin
			cdt_dl[i]   <= cdt_dl[i-1];
			c15dt_dl[i] <= c15dt_dl[i-1];
			gx_dl[i]    <= gx_dl[i-1];
			gy_dl[i]    <= gy_dl[i-1];
			gz_dl[i]    <= gz_dl[i-1];
		end
		for (int i = 1; i < SM_LAT + 1; i++) t1_dl[i] <= t1_dl[i-1];
		for (int i = 1; i < N_E; i++)      e_dl[i]     <= e_dl[i-1];
	end

	// ---------------- deviation from the ideal distance ----------------
	logic signed [35:0] dev;
	assign dev = $signed({2'b0, rac}) - $signed({5'b0, ideal_dl[N_IDEAL-1]});

	always_ff @(posedge clk) begin
		dt_q <= {{12{dev[35]}}, dev, 16'b0};
	end

	// first multiply level: dt2, c*dt, 1.5c*dt, 2uk*dt
	ubt_smul u_dt2   (.clk(clk), .a(dt_q), .b(dt_q),              .p(dt2));
	ubt_smul u_cdt   (.clk(clk), .a(c64),  .b(dt_q),              .p(cdt));
	ubt_smul u_c15dt (.clk(clk), .a(c15),  .b(dt_q),              .p(c15dt));
	ubt_smul u_t1    (.clk(clk), .a(u2k_dl[N_U2K-1]), .b(dt_q),   .p(t1));

	// second level: terms on dt2
	ubt_smul u_qdt2  (.clk(clk), .a(q64),  .b(dt2),               .p(qdt2));
	ubt_smul u_q2dt2 (.clk(clk), .a(q2),   .b(dt2),               .p(q2dt2));
	ubt_smul u_ukdt2 (.clk(clk), .a(uk_dl[N_UK-1]), .b(dt2),      .p(ukdt2));

	// anharmonic polynomials for energy and derivative
	always_ff @(posedge clk) begin
		poly_s  <= sadd(sadd(Q_ONE, cdt_dl[SM_LAT-1]), qdt2);
		poly2_s <= sadd(sadd(Q_ONE, c15dt_dl[SM_LAT-1]), q2dt2);
		ukdt2_s <= ukdt2;
	end

	// third level: energy and dE/dr
	ubt_smul u_e     (.clk(clk), .a(ukdt2_s),         .b(poly_s),  .p(e));
	ubt_smul u_deddt (.clk(clk), .a(t1_dl[SM_LAT]),   .b(poly2_s), .p(deddt));

	// divide by the distance
	ubt_div u_div (.clk(clk), .n(deddt), .d(rac_dl[N_RAC-1]), .q(de));

	// gradient on the first atom
	logic signed [63:0] qx_de, qy_de, qz_de, qx_g, qy_g, qz_g;
	assign qx_de = {{15{dx_dl[N_DDE-1][32]}}, dx_dl[N_DDE-1], 16'b0};
	assign qy_de = {{15{dy_dl[N_DDE-1][32]}}, dy_dl[N_DDE-1], 16'b0};
	assign qz_de = {{15{dz_dl[N_DDE-1][32]}}, dz_dl[N_DDE-1], 16'b0};
	assign qx_g  = {{15{dx_dl[N_DG-1][32]}}, dx_dl[N_DG-1], 16'b0};
	assign qy_g  = {{15{dy_dl[N_DG-1][32]}}, dy_dl[N_DG-1], 16'b0};
	assign qz_g  = {{15{dz_dl[N_DG-1][32]}}, dz_dl[N_DG-1], 16'b0};

	ubt_smul u_gx (.clk(clk), .a(de), .b(qx_de), .p(gx));
	ubt_smul u_gy (.clk(clk), .a(de), .b(qy_de), .p(gy));
	ubt_smul u_gz (.clk(clk), .a(de), .b(qz_de), .p(gz));

	// virial products
	ubt_smul u_vxx (.clk(clk), .a(qx_g), .b(gx), .p(vxx));
	ubt_smul u_vyx (.clk(clk), .a(qy_g), .b(gx), .p(vyx));
	ubt_smul u_vzx (.clk(clk), .a(qz_g), .b(gx), .p(vzx));
	ubt_smul u_vyy (.clk(clk), .a(qy_g), .b(gy), .p(vyy));
	ubt_smul u_vzy (.clk(clk), .a(qz_g), .b(gy), .p(vzy));
	ubt_smul u_vzz (.clk(clk), .a(qz_g), .b(gz), .p(vzz));

	// ---------------- result register with output enables ----------------
	logic en_g, en_v;
	assign en_g = en_grad_q;
	assign en_v = en_grad_q && en_vir_q;

	always_ff @(posedge clk) begin
		result.out_first_atom  <= atom_dl[N_ATOM-1][31:16];
		result.out_second_atom <= atom_dl[N_ATOM-1][15:0];
		result.energy    <= en_energy_q ? e_dl[N_E-1] : '0;
		result.grad_x    <= en_g ? gx_dl[SM_LAT-1] : '0;
		result.grad_y    <= en_g ? gy_dl[SM_LAT-1] : '0;
		result.grad_z    <= en_g ? gz_dl[SM_LAT-1] : '0;
		result.virial_xx <= en_v ? vxx : '0;
		result.virial_yx <= en_v ? vyx : '0;
		result.virial_zx <= en_v ? vzx : '0;
		result.virial_yy <= en_v ? vyy : '0;
		result.virial_zy <= en_v ? vzy : '0;
		result.virial_zz <= en_v ? vzz : '0;
	end

endmodule

FILE: hdl/ubt_smul.sv
// ----------------------------------------------------------------------------
// ubt_smul
// Pipelined Q32.32 multiply, magnitude truncated, saturated to 64 bits.
// ----------------------------------------------------------------------------
module ubt_smul (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);
	import ubt_pkg::*;

	logic [63:0]  ma_s1, mb_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  ll_s2, lh_s2, hl_s2, hh_s2;
	logic [127:0] sum_s3;

	always_ff @(posedge clk) begin
		ma_s1  <= a[63] ? 64'(-a) : 64'(a);
		mb_s1  <= b[63] ? 64'(-b) : 64'(b);
		neg_s1 <= a[63] ^ b[63];

		// four 32x32 partial products
		ll_s2  <= ma_s1[31:0]  * mb_s1[31:0];
		lh_s2  <= ma_s1[31:0]  * mb_s1[63:32];
		hl_s2  <= ma_s1[63:32] * mb_s1[31:0];
		hh_s2  <= ma_s1[63:32] * mb_s1[63:32];
		neg_s2 <= neg_s1;

		sum_s3 <= {64'b0, ll_s2} + {32'b0, lh_s2, 32'b0} + {32'b0, hl_s2, 32'b0}
			+ {hh_s2, 64'b0};
		neg_s3 <= neg_s2;

		p <= sat_sign(|sum_s3[127:96], sum_s3[95:32], neg_s3);
	end

endmodule

FILE: hdl/ubt_sqrt.sv
// ----------------------------------------------------------------------------
// ubt_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ubt_sqrt (
	input  logic        clk,
	input  logic [67:0] r2,
	output logic [33:0] root
);
	import ubt_pkg::*;

	logic [69:0] rem_q [SQ_BITS];
	logic [33:0] res_q [SQ_BITS];

	for (genvar j = 0; j < SQ_BITS; j++) begin : g_stage
		localparam int B = SQ_BITS - 1 - j;
		logic [69:0] rem_i, trial;
		logic [33:0] res_i;
		if (j == 0) begin : g_first
			assign rem_i = 70'(r2);
			assign res_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[j-1];
			assign res_i = res_q[j-1];
		end
		// (res + 2^B)^2 - res^2
		assign trial = (70'(res_i) << (B + 1)) | (70'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (rem_i >= trial) begin
				rem_q[j] <= rem_i - trial;
				res_q[j] <= res_i | (34'(1) << B);
			end else begin
				rem_q[j] <= rem_i;
				res_q[j] <= res_i;
			end
		end
	end

	assign root = res_q[SQ_BITS-1];

endmodule

FILE: hdl/ubt_div.sv
// ----------------------------------------------------------------------------
// ubt_div
// Pipelined restoring divide of a Q32.32 value by a Q16.16 distance.
// ----------------------------------------------------------------------------
module ubt_div (
	input  logic               clk,
	input  logic signed [63:0] n,
	input  logic [33:0]        d,
	output logic signed [63:0] q
);
	import ubt_pkg::*;

	logic [DIV_BITS-1:0] num_s0;
	logic [33:0]         d_s0;
	logic                neg_s0, zero_s0;

	logic [DIV_BITS-1:0] num_q  [DIV_BITS];
	logic [DIV_BITS-1:0] quo_q  [DIV_BITS];
	logic [33:0]         rem_q  [DIV_BITS];
	logic [33:0]         d_q    [DIV_BITS];
	logic                neg_q  [DIV_BITS];
	logic                zero_q [DIV_BITS];

	always_ff @(posedge clk) begin
		num_s0  <= {(n[63] ? 64'(-n) : 64'(n)), 16'b0};
		d_s0    <= d;
		neg_s0  <= n[63];
		zero_s0 <= (d == '0);
	end

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
		logic [DIV_BITS-1:0] num_i, quo_i;
		logic [33:0]         rem_i, d_i;
		logic                neg_i, zero_i, ge;
		logic [34:0]         r;
		if (j == 0) begin : g_first
			assign num_i  = num_s0;
			assign quo_i  = '0;
			assign rem_i  = '0;
			assign d_i    = d_s0;
			assign neg_i  = neg_s0;
			assign zero_i = zero_s0;
		end else begin : g_next
			assign num_i  = num_q[j-1];
			assign quo_i  = quo_q[j-1];
			assign rem_i  = rem_q[j-1];
			assign d_i    = d_q[j-1];
			assign neg_i  = neg_q[j-1];
			assign zero_i = zero_q[j-1];
		end
		assign r  = {rem_i, num_i[DIV_BITS-1]};
		assign ge = (r >= {1'b0, d_i});
		always_ff @(posedge clk) begin
			rem_q[j]  <= ge ? 34'(r - {1'b0, d_i}) : r[33:0];
			quo_q[j]  <= {quo_i[DIV_BITS-2:0], ge};
			num_q[j]  <= num_i << 1;
			d_q[j]    <= d_i;
			neg_q[j]  <= neg_i;
			zero_q[j] <= zero_i;
		end
	end

	// zero distance gives zero
	always_ff @(posedge clk) begin
		q <= zero_q[DIV_BITS-1] ? '0 :
			sat_sign(|quo_q[DIV_BITS-1][DIV_BITS-1:64], quo_q[DIV_BITS-1][63:0],
				neg_q[DIV_BITS-1]);
	end

endmodule
